[sv/cov_acc_pkg.sv]
// ----------------------------------------------------------------------------
// Coverage accumulation package
// Shared constants, register codes and arithmetic helpers for the coverage
// accumulator and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cov_acc_pkg;

	localparam int MAX_RASTER_WIDTH_DEF = 1024;

	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USER_W = 2;

	localparam int PIX_LSB  = 0;
	localparam int ROW_LSB  = 24;
	localparam int COL_LSB  = 40;
	localparam int PAD_LSB  = 50;

	localparam int USER_VISIBLE  = 0;
	localparam int USER_RESIDUAL = 1;

	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_idx_t;

	function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic signed [16:0] s;
		logic signed [15:0] r;
		s = $signed({a[15], a}) + $signed({b[15], b});
		if (s[16] != s[15]) begin
			r = s[16] ? 16'sh8000 : 16'sh7FFF;
		end else begin
			r = s[15:0];
		end
		return r;
	endfunction

	function automatic logic [7:0] clamp_gray(input logic signed [15:0] v);
		logic [7:0] g;
		if (v[15]) begin
			g = 8'h00;
		end else if (|v[14:8]) begin
			g = 8'hFF;
		end else begin
			g = v[7:0];
		end
		return g;
	endfunction

endpackage

`default_nettype wire

[sv/coverage_accumulate_to_pixels.sv]
// ----------------------------------------------------------------------------
// Coverage accumulate to pixels
// Turns signed-area raster cells into gray pixels, one cell per cycle unless
// m_axis stalls, keeping one running sum per raster column in a memory.
// ----------------------------------------------------------------------------
// Usage: raster cells enter on the s_axis channel in row-major order over the
// raster width (image width rounded up to 8). Each cell request produces one
// pixel request on the m_axis channel, with tlast on the last cell of the
// image. cfg_ready is always high. The cfg channel writes image width (index
// 0) and image height (index 1); every write restarts the image at row 0,
// column 0. Writes must be made only while the block is idle (not enforced).
// An accepted cell passes through the compute stage and then the output
// register to m_axis. Throughput is one cell per cycle while m_axis is not
// stalled, with one read of the column-sum memory when a cell is accepted
// and one write when it leaves the compute stage. A column is revisited at
// least eight cells later, so read and write never overlap on the same entry.
// When the receiver stalls, the output register and the compute stage fill
// and then s_axis_tready drops. Reset clears the pipeline, the counters and
// the registers (width 1, height 1); column sums are not cleared, since row 0
// ignores what the memory holds.
// ----------------------------------------------------------------------------
`default_nettype none

module coverage_accumulate_to_pixels #(
	parameter int MAX_RASTER_WIDTH = cov_acc_pkg::MAX_RASTER_WIDTH_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire cov_acc_pkg::cfg_idx_t            cfg_index,
	input  wire [cov_acc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	// Fields from bit 0: edge_delta[15:0], tail_delta[31:16].
	input  wire [cov_acc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	// Fields from bit 0: pixel_word[23:0], out_row[39:24], out_column[49:40],
	// zero fill [55:50].
	output logic [cov_acc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// Fields from bit 0: visible[0], residual_error[1].
	output logic [cov_acc_pkg::OUT_USER_W-1:0]    m_axis_tuser,
	output logic                                  m_axis_tlast
);

	import cov_acc_pkg::*;

	localparam int COL_W = (MAX_RASTER_WIDTH > 1) ? $clog2(MAX_RASTER_WIDTH) : 1;
	localparam int DIM_W = (COL_W + 2 > 12) ? COL_W + 2 : 12;
	localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_RASTER_WIDTH);

	logic [10:0]           width_q;
	logic [15:0]           height_q;
	logic [COL_W-1:0]      col_q;
	logic [15:0]           row_q;

	logic [DIM_W-1:0]      eff_w;
	logic [DIM_W-1:0]      eff_w_p7;
	logic [DIM_W-1:0]      rnd_w;
	logic [DIM_W-1:0]      raster_w;
	logic [DIM_W-1:0]      col_p1;
	logic [15:0]           height_m1;
	logic                  last_col;
	logic                  last_row;
	logic                  in_fire;
	logic                  cfg_fire;
	logic                  adv_s1;

	logic                  valid_s1;
	logic signed [15:0]    edge_s1;
	logic signed [15:0]    tail_s1;
	logic signed [15:0]    rd_s1;
	logic [COL_W-1:0]      col_s1;
	logic [15:0]           row_s1;
	logic                  row0_s1;
	logic                  last_col_s1;
	logic                  last_row_s1;
	logic                  vis_s1;

	logic signed [15:0]    base_sum;
	logic signed [15:0]    cov_sum;
	logic signed [15:0]    new_sum;
	logic [7:0]            gray;

	logic                  m_valid_q;
	logic [23:0]           pixel_q;
	logic [15:0]           out_row_q;
	logic [9:0]            out_col_q;
	logic                  vis_q;
	logic                  resid_q;
	logic                  done_q;

	logic signed [15:0]    sums_mem [MAX_RASTER_WIDTH];

	always_comb begin
		if (width_q == 11'd0) begin
			eff_w = DIM_W'(1);
		end else if (DIM_W'(width_q) > MAX_W) begin
			eff_w = MAX_W;
		end else begin
			eff_w = DIM_W'(width_q);
		end
		eff_w_p7  = eff_w + DIM_W'(7);
		rnd_w     = {eff_w_p7[DIM_W-1:3], 3'b000};
		raster_w  = (rnd_w > MAX_W) ? MAX_W : rnd_w;
		col_p1    = DIM_W'(col_q) + DIM_W'(1);
		last_col  = (col_p1 >= raster_w);
		height_m1 = (height_q == 16'd0) ? 16'd0 : height_q - 16'd1;
		last_row  = (row_q >= height_m1);
	end

	assign cfg_ready     = 1'b1;
	assign cfg_fire      = cfg_valid & cfg_ready;
	assign adv_s1        = valid_s1 & (~m_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | adv_s1;
	assign in_fire       = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1;
			height_q <= 16'd1;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH: begin
					width_q <= cfg_data[10:0];
				end
				CFG_IMAGE_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			edge_s1     <= s_axis_tdata[15:0];
			tail_s1     <= s_axis_tdata[31:16];
			col_s1      <= col_q;
			row_s1      <= row_q;
			row0_s1     <= (row_q == 16'd0);
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
			vis_s1      <= (DIM_W'(col_q) < eff_w);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_s1 <= sums_mem[col_q];
		end
		if (adv_s1) begin
			sums_mem[col_s1] <= new_sum;
		end
	end

	always_comb begin
		base_sum = row0_s1 ? 16'sd0 : rd_s1;
		cov_sum  = sat_add16(base_sum, edge_s1);
		new_sum  = sat_add16(base_sum, tail_s1);
		gray     = clamp_gray(cov_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pixel_q   <= {gray, gray, gray};
			out_row_q <= row_s1;
			out_col_q <= 10'(col_s1);
			vis_q     <= vis_s1;
			resid_q   <= last_row_s1 & (new_sum != 16'sd0);
			done_q    <= last_row_s1 & last_col_s1;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'b000000, out_col_q, out_row_q, pixel_q};
	assign m_axis_tuser  = {resid_q, vis_q};
	assign m_axis_tlast  = done_q;

endmodule

`default_nettype wire

[sv/cov_acc_chk.sv]
// ----------------------------------------------------------------------------
// Coverage accumulation port checker
// Watches the ports of the coverage accumulator for output holding, pixel
// formatting and back-pressure behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module cov_acc_chk (
	input wire                                   clk,
	input wire                                   arst_n,
	input wire                                   s_axis_tready,
	input wire                                   m_axis_tvalid,
	input wire                                   m_axis_tready,
	input wire [cov_acc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input wire [cov_acc_pkg::OUT_USER_W-1:0]     m_axis_tuser,
	input wire                                   m_axis_tlast
);

	import cov_acc_pkg::*;

	// A stalled pixel request keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
		$stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("pixel request changed while stalled");

	// The gray value is the same in all three bytes.
	a_gray_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[PIX_LSB+7:PIX_LSB] ==
		m_axis_tdata[PIX_LSB+15:PIX_LSB+8]) && (m_axis_tdata[PIX_LSB+7:PIX_LSB] ==
		m_axis_tdata[PIX_LSB+23:PIX_LSB+16]))
		else $error("gray bytes differ in pixel word");

	// The fill bits above the column are zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:PAD_LSB] == '0)
		else $error("fill bits of output data not zero");

	// Cells are refused only while a finished pixel waits to be taken.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

endmodule

bind coverage_accumulate_to_pixels cov_acc_chk u_cov_acc_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[tb/sv/coverage_accumulate_to_pixels_tb.sv]
// ----------------------------------------------------------------------------
// Coverage accumulate to pixels testbench
// Streams raster cells into the accumulator and predicts each gray pixel from
// its own copy of the column sums, counters and registers. Directed tests
// cover reset defaults, saturation and register extremes. Random images with
// random sizes, fill styles and flow control on both sides follow.
// ----------------------------------------------------------------------------

module coverage_accumulate_to_pixels_tb;

	import cov_acc_pkg::*;

	localparam int MAX_COLS     = MAX_RASTER_WIDTH_DEF;
	localparam int RANDOM_CELLS = 100;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE       = 6;

	typedef struct packed {
		logic [23:0] pixel_word;
		logic        visible;
		logic [15:0] row;
		logic [9:0]  column;
		logic        residual;
		logic        done;
	} pixel_t;

	typedef enum {FILL_BALANCED, FILL_WILD, FILL_EXTREME} fill_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// Fields from bit 0: edge_delta[15:0], tail_delta[31:16].
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// Fields from bit 0: pixel_word[23:0], out_row[39:24], out_column[49:40].
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// Fields from bit 0: visible[0], residual_error[1].
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  m_axis_tlast;

	coverage_accumulate_to_pixels dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Predicted block state, updated on every accepted request.
	logic [10:0]        pred_width;
	logic [15:0]        pred_height;
	logic signed [15:0] col_sum [MAX_COLS];
	int                 row_at;
	int                 col_at;
	pixel_t             pixels_due [$];

	// Stimulus side view of the registers and of the tail sums per column.
	int  cur_width;
	int  cur_height;
	int  tail_balance [MAX_COLS];
	bit  tx_burst;
	bit  rx_burst;
	int  faults;
	int  cycles;

	function automatic int visible_cols(input int w);
		int e;
		e = w;
		if (e < 1) e = 1;
		if (e > MAX_COLS) e = MAX_COLS;
		return e;
	endfunction

	function automatic int raster_cols(input int w);
		int r;
		r = (visible_cols(w) + 7) / 8 * 8;
		if (r > MAX_COLS) r = MAX_COLS;
		return r;
	endfunction

	function automatic int clip16(input int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	task automatic predict_pixel(input logic signed [15:0] edge_d,
		input logic signed [15:0] tail_d);
		int     rw;
		int     h;
		int     acc;
		int     cov;
		logic   last_col;
		logic   last_row;
		pixel_t p;
		rw = raster_cols(int'(pred_width));
		h = (pred_height == 16'd0) ? 1 : int'(pred_height);
		last_col = (col_at + 1) >= rw;
		last_row = (row_at + 1) >= h;
		acc = (row_at != 0) ? int'(col_sum[col_at]) : 0;
		cov = clip16(acc + int'(edge_d));
		acc = clip16(acc + int'(tail_d));
		col_sum[col_at] = acc[15:0];
		if (cov < 0) cov = 0;
		if (cov > 255) cov = 255;
		p.pixel_word = {3{cov[7:0]}};
		p.visible = col_at < visible_cols(int'(pred_width));
		p.row = row_at[15:0];
		p.column = col_at[9:0];
		p.residual = last_row && (acc != 0);
		p.done = last_row && last_col;
		pixels_due.push_back(p);
		if (last_col) begin
			col_at = 0;
			row_at = last_row ? 0 : row_at + 1;
		end else begin
			col_at = col_at + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_width = 11'd1;
			pred_height = 16'd1;
			row_at = 0;
			col_at = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_IMAGE_WIDTH) begin
					pred_width = cfg_data[10:0];
				end else begin
					pred_height = cfg_data;
				end
				row_at = 0;
				col_at = 0;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_pixel(s_axis_tdata[15:0], s_axis_tdata[31:16]);
			end
		end
	end

	task automatic compare(input string field, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			faults++;
		end
	endtask

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pixels_due.size() == 0) begin
				$error("pixel request with no cell waiting for it");
				faults++;
			end else begin
				want = pixels_due.pop_front();
				compare("pixel_word", want.pixel_word, m_axis_tdata[PIX_LSB +: 24]);
				compare("visible", want.visible, m_axis_tuser[USER_VISIBLE]);
				compare("out_row", want.row, m_axis_tdata[ROW_LSB +: 16]);
				compare("out_column", want.column, m_axis_tdata[COL_LSB +: 10]);
				compare("residual_error", want.residual, m_axis_tuser[USER_RESIDUAL]);
				compare("image_done", want.done, m_axis_tlast);
				compare("zero_fill", 0, m_axis_tdata[OUT_DATA_W-1:PAD_LSB]);
			end
		end
	end

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("coverage_accumulate_to_pixels regression: fail");
			$finish;
		end
	end

	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 17);
			@(negedge clk);
			if (stall != 0) begin
				m_axis_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_cell(input logic [15:0] edge_d, input logic [15:0] tail_d);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {tail_d, edge_d};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [15:0] value);
		wait_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == CFG_IMAGE_WIDTH) begin
			cur_width = int'(value[10:0]);
		end else begin
			cur_height = int'(value);
		end
	endtask

	function automatic logic [15:0] pick_extreme();
		case ($urandom_range(0, 6))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4: return 16'h00FF;
			5: return 16'h0100;
			default: return 16'($urandom());
		endcase
	endfunction

	// Cells start at row 0, column 0 of the current image.
	task automatic send_cells(input int count, input fill_t fill);
		int                 rw;
		int                 h;
		int                 r;
		int                 c;
		int                 v;
		logic signed [15:0] ed;
		logic signed [15:0] td;
		rw = raster_cols(cur_width);
		h = (cur_height == 0) ? 1 : cur_height;
		for (int k = 0; k < count; k++) begin
			c = k % rw;
			r = (k / rw) % h;
			case (fill)
				FILL_BALANCED: begin
					v = $urandom_range(0, 700);
					ed = 16'(v - 350);
					if (r == 0) tail_balance[c] = 0;
					if (r == h - 1) begin
						td = 16'(-tail_balance[c]);
					end else begin
						v = $urandom_range(0, 1000);
						td = 16'(v - 500);
					end
					tail_balance[c] += int'(td);
				end
				FILL_WILD: begin
					ed = 16'($urandom());
					td = 16'($urandom());
				end
				default: begin
					ed = pick_extreme();
					td = pick_extreme();
				end
			endcase
			send_cell(ed, td);
		end
	endtask

	task automatic test_reset_defaults();
		logic [15:0] ev [8];
		logic [15:0] tv [8];
		ev = '{16'h0000, 16'h00FF, 16'h0100, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0080, 16'h0001};
		tv = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000};
		tx_burst = 1'b1;
		rx_burst = 1'b0;
		for (int k = 0; k < 8; k++) send_cell(ev[k], tv[k]);
	endtask

	task automatic test_saturation();
		logic [15:0] ev [16];
		logic [15:0] tv [16];
		ev = '{16'h0010, 16'h0000, 16'h0000, 16'hFF00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'h00FF, 16'h0000, 16'h7FFF, 16'h0001};
		tv = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h0064, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h7FFF, 16'h8000, 16'h8001, 16'hFF9C, 16'h0001, 16'h0000, 16'h0000, 16'h0000};
		write_register(CFG_IMAGE_WIDTH, 16'd3);
		write_register(CFG_IMAGE_HEIGHT, 16'd2);
		tx_burst = 1'b0;
		rx_burst = 1'b1;
		for (int k = 0; k < 16; k++) send_cell(ev[k], tv[k]);
	endtask

	task automatic test_register_extremes();
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		write_register(CFG_IMAGE_WIDTH, 16'd0);
		write_register(CFG_IMAGE_HEIGHT, 16'd0);
		send_cells(16, FILL_WILD);
		write_register(CFG_IMAGE_WIDTH, 16'hFFFF);
		write_register(CFG_IMAGE_HEIGHT, 16'd1);
		tx_burst = 1'b1;
		send_cells(1024 + 8, FILL_EXTREME);
		write_register(CFG_IMAGE_WIDTH, 16'd9);
		write_register(CFG_IMAGE_HEIGHT, 16'hFFFF);
		tx_burst = 1'b0;
		rx_burst = 1'b1;
		send_cells(100, FILL_WILD);
	endtask

	task automatic test_random_images();
		int    sent;
		int    w;
		int    hh;
		int    per_image;
		int    count;
		fill_t fill;
		sent = 0;
		write_register(CFG_IMAGE_HEIGHT, 16'd1);
		while (sent < RANDOM_CELLS) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 128) : $urandom_range(1, 40);
			hh = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
			case ($urandom_range(0, 3))
				0: write_register(CFG_IMAGE_WIDTH, w[15:0]);
				1: write_register(CFG_IMAGE_HEIGHT, hh[15:0]);
				2: begin
					write_register(CFG_IMAGE_HEIGHT, hh[15:0]);
					write_register(CFG_IMAGE_WIDTH, w[15:0]);
				end
				default: begin
					write_register(CFG_IMAGE_WIDTH, w[15:0]);
					write_register(CFG_IMAGE_HEIGHT, hh[15:0]);
				end
			endcase
			case ($urandom_range(0, 9))
				0, 1: fill = FILL_WILD;
				2: fill = FILL_EXTREME;
				default: fill = FILL_BALANCED;
			endcase
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			per_image = raster_cols(cur_width) * ((cur_height == 0) ? 1 : cur_height);
			count = per_image * $urandom_range(1, 2);
			if ($urandom_range(0, 4) == 0) count += $urandom_range(1, per_image - 1);
			if (count > RANDOM_CELLS - sent) count = RANDOM_CELLS - sent;
			send_cells(count, fill);
			sent += count;
		end
	endtask

	initial begin
		faults = 0;
		cycles = 0;
		cur_width = 1;
		cur_height = 1;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_saturation();
		test_register_extremes();
		test_random_images();
		wait_drained();
		if (faults == 0) begin
			$display("coverage_accumulate_to_pixels regression: pass");
		end else begin
			$display("coverage_accumulate_to_pixels regression: fail");
		end
		$finish;
	end

endmodule
